### rtl/core/gci_pkg.sv
// Shared types, codes and constants of the color gradient interpolator.
`default_nettype none

package gci_pkg;

   localparam int MAX_STOPS_DEFAULT = 16;
   localparam int KEY_W             = 17;
   localparam int COLOR_W           = 24;
   localparam int CH_W              = 8;
   localparam int STATUS_W          = 2;
   localparam int NUM_W             = 24;
   localparam int BIT_W             = 3;

   localparam logic [KEY_W-1:0] KEY_ONE = 17'h10000;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_COLOR   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd3;

   localparam logic [1:0] CHAN_RED   = 2'd0;
   localparam logic [1:0] CHAN_GREEN = 2'd1;
   localparam logic [1:0] CHAN_BLUE  = 2'd2;

   typedef enum logic [2:0] {
      RD_IDX,
      RD_IDX_P1,
      RD_IDX_M1,
      RD_SH_M1,
      RD_SH_M2
   } gci_rd_sel_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_EQ,
      WR_SHIFT,
      WR_INS
   } gci_wr_op_type;

   typedef enum logic [1:0] {
      RSP_NONE,
      RSP_READ,
      RSP_COLOR0,
      RSP_BLEND
   } gci_rsp_sel_type;

   typedef struct packed {
      logic                  accept;
      logic                  rd_en;
      gci_rd_sel_type        rd_sel;
      gci_wr_op_type         wr_op;
      logic                  idx_inc;
      logic                  sh_load;
      logic                  sh_dec;
      logic                  save_hi;
      logic                  save_lo;
      logic                  mul;
      logic                  div_step;
      logic                  chan_next;
      logic                  rsp_load;
      gci_rsp_sel_type       rsp_sel;
      logic [STATUS_W-1:0]   rsp_status;
   } gci_cmd_type;

   typedef struct packed {
      logic pos_invalid;
      logic is_lookup;
      logic key_eq;
      logic key_gt;
      logic scan_last;
      logic idx_zero;
      logic full;
      logic sh_eq_pos;
      logic sh_m1_eq_pos;
      logic div_last;
      logic chan_last;
      logic rsp_free;
   } gci_stat_type;

endpackage

`default_nettype wire

### rtl/core/gci_datapath.sv
// Stop table, scan and shift indexes, shared blend multiply and divider, result register.
`default_nettype none

module gci_datapath #(
   parameter int MAX_STOPS = gci_pkg::MAX_STOPS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire gci_pkg::gci_cmd_type          cmd,
   output gci_pkg::gci_stat_type              stat,
   input  wire logic                          req_type,
   input  wire logic [gci_pkg::KEY_W-1:0]     req_position,
   input  wire logic [gci_pkg::CH_W-1:0]      req_stop_red,
   input  wire logic [gci_pkg::CH_W-1:0]      req_stop_green,
   input  wire logic [gci_pkg::CH_W-1:0]      req_stop_blue,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [gci_pkg::STATUS_W-1:0]       rsp_status,
   output logic [gci_pkg::CH_W-1:0]           rsp_out_red,
   output logic [gci_pkg::CH_W-1:0]           rsp_out_green,
   output logic [gci_pkg::CH_W-1:0]           rsp_out_blue
);

   localparam int IW = $clog2(MAX_STOPS);
   localparam int CW = $clog2(MAX_STOPS + 1);
   localparam int KW = gci_pkg::KEY_W;
   localparam int RW = gci_pkg::COLOR_W;
   localparam int HW = gci_pkg::CH_W;
   localparam int NW = gci_pkg::NUM_W;
   localparam int BW = gci_pkg::BIT_W;

   logic [KW-1:0] stop_key_ff   [MAX_STOPS];
   logic [RW-1:0] stop_color_ff [MAX_STOPS];

   logic          req_type_ff, req_type_in;
   logic [KW-1:0] pos_ff, pos_in;
   logic [RW-1:0] rgb_ff, rgb_in;
   logic [CW-1:0] count_ff, count_in;
   logic [RW-1:0] color0_ff, color0_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] sh_ff, sh_in;
   logic [KW-1:0] mem_key_ff;
   logic [RW-1:0] mem_color_ff;
   logic          rd_zero_ff;
   logic [KW-1:0] uk_ff, uk_in, lk_ff, lk_in;
   logic [RW-1:0] hc_ff, hc_in, lc_ff, lc_in;
   logic [NW-1:0] rem_ff, rem_in;
   logic [KW-1:0] den_ff, den_in;
   logic [HW-1:0] quo_ff, quo_in;
   logic [BW-1:0] bit_ff, bit_in;
   logic [1:0]    chan_ff, chan_in;
   logic [HW-1:0] red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [gci_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [RW-1:0]                 rsp_color_ff, rsp_color_in;

   logic [CW-1:0] idx_p1, idx_m1, sh_m1, sh_m2, rd_idx;
   logic [IW-1:0] rd_addr, wr_addr;
   logic [KW-1:0] rd_key, wr_key;
   logic [RW-1:0] rd_color, wr_color;
   logic [CW-1:0] wr_idx;
   logic          wr_any, mem_we, color0_we;
   logic [HW-1:0] lo_ch, hi_ch;
   logic [KW-1:0] up_gap, lo_gap;
   logic [NW:0]   prod_lo, prod_hi, num_sum;
   logic [NW-1:0] den_shift;

   assign idx_p1 = idx_ff + CW'(1);
   assign idx_m1 = idx_ff - CW'(1);
   assign sh_m1  = sh_ff - CW'(1);
   assign sh_m2  = sh_ff - CW'(2);

   always_comb begin
      unique case (cmd.rd_sel)
         gci_pkg::RD_IDX:    rd_idx = idx_ff;
         gci_pkg::RD_IDX_P1: rd_idx = idx_p1;
         gci_pkg::RD_IDX_M1: rd_idx = idx_m1;
         gci_pkg::RD_SH_M1:  rd_idx = sh_m1;
         gci_pkg::RD_SH_M2:  rd_idx = sh_m2;
         default:            rd_idx = idx_ff;
      endcase
   end
   assign rd_addr = rd_idx[IW-1:0];

   assign rd_key   = rd_zero_ff ? '0 : mem_key_ff;
   assign rd_color = rd_zero_ff ? color0_ff : mem_color_ff;

   always_comb begin
      unique case (cmd.wr_op)
         gci_pkg::WR_SHIFT: begin
            wr_idx   = sh_ff;
            wr_key   = rd_key;
            wr_color = rd_color;
         end
         default: begin
            wr_idx   = idx_ff;
            wr_key   = pos_ff;
            wr_color = rgb_ff;
         end
      endcase
   end
   assign wr_addr   = wr_idx[IW-1:0];
   assign wr_any    = cmd.wr_op != gci_pkg::WR_NONE;
   assign color0_we = wr_any && (wr_addr == '0);
   assign mem_we    = wr_any && (wr_addr != '0);

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         mem_key_ff   <= stop_key_ff[rd_addr];
         mem_color_ff <= stop_color_ff[rd_addr];
         rd_zero_ff   <= rd_addr == '0;
      end
      if (mem_we) begin
         stop_key_ff[wr_addr]   <= wr_key;
         stop_color_ff[wr_addr] <= wr_color;
      end
   end

   always_comb begin
      unique case (chan_ff)
         gci_pkg::CHAN_RED: begin
            lo_ch = lc_ff[23:16];
            hi_ch = hc_ff[23:16];
         end
         gci_pkg::CHAN_GREEN: begin
            lo_ch = lc_ff[15:8];
            hi_ch = hc_ff[15:8];
         end
         default: begin
            lo_ch = lc_ff[7:0];
            hi_ch = hc_ff[7:0];
         end
      endcase
   end

   assign up_gap    = uk_ff - pos_ff;
   assign lo_gap    = pos_ff - lk_ff;
   assign prod_lo   = (NW+1)'(lo_ch) * (NW+1)'(up_gap);
   assign prod_hi   = (NW+1)'(hi_ch) * (NW+1)'(lo_gap);
   assign num_sum   = prod_lo + prod_hi;
   assign den_shift = NW'(den_ff) << bit_ff;

   always_comb begin
      req_type_in   = req_type_ff;
      pos_in        = pos_ff;
      rgb_in        = rgb_ff;
      idx_in        = idx_ff;
      sh_in         = sh_ff;
      count_in      = count_ff;
      color0_in     = color0_ff;
      uk_in         = uk_ff;
      hc_in         = hc_ff;
      lk_in         = lk_ff;
      lc_in         = lc_ff;
      rem_in        = rem_ff;
      den_in        = den_ff;
      quo_in        = quo_ff;
      bit_in        = bit_ff;
      chan_in       = chan_ff;
      red_in        = red_ff;
      green_in      = green_ff;
      blue_in       = blue_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_color_in  = rsp_color_ff;

      if (cmd.accept) begin
         req_type_in = req_type;
         pos_in      = req_position;
         rgb_in      = {req_stop_red, req_stop_green, req_stop_blue};
         idx_in      = '0;
         chan_in     = gci_pkg::CHAN_RED;
      end else if (cmd.idx_inc) begin
         idx_in = idx_p1;
      end

      if (cmd.sh_load) begin
         sh_in = count_ff;
      end else if (cmd.sh_dec) begin
         sh_in = sh_m1;
      end

      if (cmd.wr_op == gci_pkg::WR_INS) begin
         count_in = count_ff + CW'(1);
      end
      if (color0_we) begin
         color0_in = wr_color;
      end

      if (cmd.save_hi) begin
         uk_in = rd_key;
         hc_in = rd_color;
      end
      if (cmd.save_lo) begin
         lk_in = rd_key;
         lc_in = rd_color;
      end

      if (cmd.mul) begin
         rem_in = num_sum[NW-1:0];
         den_in = uk_ff - lk_ff;
         quo_in = '0;
         bit_in = BW'(HW - 1);
      end else if (cmd.div_step) begin
         if (rem_ff >= den_shift) begin
            rem_in         = rem_ff - den_shift;
            quo_in[bit_ff] = 1'b1;
         end
         bit_in = bit_ff - BW'(1);
      end

      if (cmd.chan_next) begin
         case (chan_ff)
            gci_pkg::CHAN_RED:   red_in   = quo_ff;
            gci_pkg::CHAN_GREEN: green_in = quo_ff;
            default:             blue_in  = quo_ff;
         endcase
         chan_in = chan_ff + 2'd1;
      end

      if (cmd.rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = cmd.rsp_status;
         unique case (cmd.rsp_sel)
            gci_pkg::RSP_READ:   rsp_color_in = rd_color;
            gci_pkg::RSP_COLOR0: rsp_color_in = color0_ff;
            gci_pkg::RSP_BLEND:  rsp_color_in = {red_ff, green_ff, blue_ff};
            default:             rsp_color_in = '0;
         endcase
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= CW'(1);
         color0_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         color0_ff    <= color0_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_type_ff   <= req_type_in;
      pos_ff        <= pos_in;
      rgb_ff        <= rgb_in;
      idx_ff        <= idx_in;
      sh_ff         <= sh_in;
      uk_ff         <= uk_in;
      hc_ff         <= hc_in;
      lk_ff         <= lk_in;
      lc_ff         <= lc_in;
      rem_ff        <= rem_in;
      den_ff        <= den_in;
      quo_ff        <= quo_in;
      bit_ff        <= bit_in;
      chan_ff       <= chan_in;
      red_ff        <= red_in;
      green_ff      <= green_in;
      blue_ff       <= blue_in;
      rsp_status_ff <= rsp_status_in;
      rsp_color_ff  <= rsp_color_in;
   end

   assign stat.pos_invalid  = pos_ff > gci_pkg::KEY_ONE;
   assign stat.is_lookup    = req_type_ff == gci_pkg::REQ_LOOKUP;
   assign stat.key_eq       = rd_key == pos_ff;
   assign stat.key_gt       = rd_key > pos_ff;
   assign stat.scan_last    = idx_p1 == count_ff;
   assign stat.idx_zero     = idx_ff == '0;
   assign stat.full         = count_ff == CW'(MAX_STOPS);
   assign stat.sh_eq_pos    = sh_ff == idx_ff;
   assign stat.sh_m1_eq_pos = sh_m1 == idx_ff;
   assign stat.div_last     = bit_ff == '0;
   assign stat.chan_last    = chan_ff == gci_pkg::CHAN_BLUE;
   assign stat.rsp_free     = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_red   = rsp_color_ff[23:16];
   assign rsp_out_green = rsp_color_ff[15:8];
   assign rsp_out_blue  = rsp_color_ff[7:0];

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CW'(1)) && (count_ff <= CW'(MAX_STOPS)))
      else $error("stop count out of range");

   a_rsp_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten while stalled");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_op == gci_pkg::WR_INS) |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("insert did not grow the table");
`endif

endmodule

`default_nettype wire

### rtl/core/gci_controller.sv
// Sequencer for table scan, stop insertion, per-channel blend and result hand-off.
`default_nettype none

module gci_controller (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   output gci_pkg::gci_cmd_type        cmd,
   input  wire gci_pkg::gci_stat_type  stat
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_LO_CAP,
      S_INS_CHECK,
      S_SH_CHK,
      S_SH_WR,
      S_INS_WR,
      S_MUL,
      S_DIV,
      S_CHAN,
      S_DONE
   } state_type;

   state_type                     state_ff, state_in;
   gci_pkg::gci_rsp_sel_type      rsp_sel_ff, rsp_sel_in;
   logic [gci_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;

   always_comb begin
      state_in      = state_ff;
      rsp_sel_in    = rsp_sel_ff;
      rsp_status_in = rsp_status_ff;

      cmd            = '0;
      cmd.rd_sel     = gci_pkg::RD_IDX;
      cmd.wr_op      = gci_pkg::WR_NONE;
      cmd.rsp_sel    = rsp_sel_ff;
      cmd.rsp_status = rsp_status_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.pos_invalid) begin
               state_in = S_DONE;
               if (stat.is_lookup) begin
                  rsp_sel_in    = gci_pkg::RSP_COLOR0;
                  rsp_status_in = gci_pkg::STATUS_COLOR;
               end else begin
                  rsp_sel_in    = gci_pkg::RSP_NONE;
                  rsp_status_in = gci_pkg::STATUS_INVALID;
               end
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = gci_pkg::RD_IDX;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            if (!stat.is_lookup) begin
               if (stat.key_eq) begin
                  cmd.wr_op     = gci_pkg::WR_EQ;
                  rsp_sel_in    = gci_pkg::RSP_NONE;
                  rsp_status_in = gci_pkg::STATUS_OK;
                  state_in      = S_DONE;
               end else if (stat.key_gt) begin
                  state_in = S_INS_CHECK;
               end else if (stat.scan_last) begin
                  cmd.idx_inc = 1'b1;
                  state_in    = S_INS_CHECK;
               end else begin
                  cmd.idx_inc = 1'b1;
                  cmd.rd_en   = 1'b1;
                  cmd.rd_sel  = gci_pkg::RD_IDX_P1;
               end
            end else begin
               if (stat.key_gt) begin
                  if (stat.idx_zero) begin
                     rsp_sel_in    = gci_pkg::RSP_READ;
                     rsp_status_in = gci_pkg::STATUS_COLOR;
                     state_in      = S_DONE;
                  end else begin
                     cmd.save_hi = 1'b1;
                     cmd.rd_en   = 1'b1;
                     cmd.rd_sel  = gci_pkg::RD_IDX_M1;
                     state_in    = S_LO_CAP;
                  end
               end else if (stat.scan_last) begin
                  rsp_sel_in    = gci_pkg::RSP_READ;
                  rsp_status_in = gci_pkg::STATUS_COLOR;
                  state_in      = S_DONE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  cmd.rd_en   = 1'b1;
                  cmd.rd_sel  = gci_pkg::RD_IDX_P1;
               end
            end
         end
         S_LO_CAP: begin
            cmd.save_lo = 1'b1;
            state_in    = S_MUL;
         end
         S_INS_CHECK: begin
            if (stat.full) begin
               rsp_sel_in    = gci_pkg::RSP_NONE;
               rsp_status_in = gci_pkg::STATUS_FULL;
               state_in      = S_DONE;
            end else begin
               cmd.sh_load = 1'b1;
               state_in    = S_SH_CHK;
            end
         end
         S_SH_CHK: begin
            if (stat.sh_eq_pos) begin
               state_in = S_INS_WR;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = gci_pkg::RD_SH_M1;
               state_in   = S_SH_WR;
            end
         end
         S_SH_WR: begin
            cmd.wr_op  = gci_pkg::WR_SHIFT;
            cmd.sh_dec = 1'b1;
            if (stat.sh_m1_eq_pos) begin
               state_in = S_INS_WR;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = gci_pkg::RD_SH_M2;
            end
         end
         S_INS_WR: begin
            cmd.wr_op     = gci_pkg::WR_INS;
            rsp_sel_in    = gci_pkg::RSP_NONE;
            rsp_status_in = gci_pkg::STATUS_OK;
            state_in      = S_DONE;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_CHAN;
            end
         end
         S_CHAN: begin
            cmd.chan_next = 1'b1;
            if (stat.chan_last) begin
               rsp_sel_in    = gci_pkg::RSP_BLEND;
               rsp_status_in = gci_pkg::STATUS_COLOR;
               state_in      = S_DONE;
            end else begin
               state_in = S_MUL;
            end
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_sel_ff    <= gci_pkg::RSP_NONE;
         rsp_status_ff <= gci_pkg::STATUS_COLOR;
      end else begin
         state_ff      <= state_in;
         rsp_sel_ff    <= rsp_sel_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;

endmodule

`default_nettype wire

### rtl/core/color_gradient_interpolator_top.sv
// Top level of the color gradient interpolator: controller and datapath.
`default_nettype none

// Holds a key-sorted table of up to MAX_STOPS gradient stops (Q.16 key, 24-bit RGB);
// after reset it holds one black stop at key 0. A request beat either inserts a stop
// or looks up the color at a position; each request returns exactly one response beat.
// One request is in flight at a time: the next request is taken only after the
// response has been loaded. An insert of a new key scans the stops in key order (one
// table read a cycle), then moves the stops above its slot up by one to make room
// (one read and one write a cycle on the table port). An insert at an equal key
// replaces the color of that stop. A lookup scans the same way; between two stops it
// blends them: it loads the lower stop, then for each of the three channels runs one
// shared multiply, eight restoring divide steps and a store. With 16 stops the
// longest item is a blended lookup. A response waits in the output register while
// rsp_stall is high; the next request can still be taken, and its own response
// then waits for the register to be free.
module color_gradient_interpolator_top #(
   parameter int MAX_STOPS = gci_pkg::MAX_STOPS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_type,
   input  wire logic [gci_pkg::KEY_W-1:0]     req_position,
   input  wire logic [gci_pkg::CH_W-1:0]      req_stop_red,
   input  wire logic [gci_pkg::CH_W-1:0]      req_stop_green,
   input  wire logic [gci_pkg::CH_W-1:0]      req_stop_blue,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [gci_pkg::STATUS_W-1:0]       rsp_status,
   output logic [gci_pkg::CH_W-1:0]           rsp_out_red,
   output logic [gci_pkg::CH_W-1:0]           rsp_out_green,
   output logic [gci_pkg::CH_W-1:0]           rsp_out_blue
);

   gci_pkg::gci_cmd_type  cmd;
   gci_pkg::gci_stat_type stat;

   gci_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   gci_datapath #(
      .MAX_STOPS (MAX_STOPS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_type       (req_type),
      .req_position   (req_position),
      .req_stop_red   (req_stop_red),
      .req_stop_green (req_stop_green),
      .req_stop_blue  (req_stop_blue),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue)
   );

endmodule

`default_nettype wire

### verif/gci_gradient_checker.sv
// Checker for the color gradient interpolator: predicts each response beat and compares it.
`default_nettype none

module gci_gradient_checker (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   input  wire logic                         req_stall,
   input  wire logic                         req_type,
   input  wire logic [gci_pkg::KEY_W-1:0]    req_position,
   input  wire logic [gci_pkg::CH_W-1:0]     req_stop_red,
   input  wire logic [gci_pkg::CH_W-1:0]     req_stop_green,
   input  wire logic [gci_pkg::CH_W-1:0]     req_stop_blue,
   input  wire logic                         rsp_valid,
   input  wire logic                         rsp_stall,
   input  wire logic [gci_pkg::STATUS_W-1:0] rsp_status,
   input  wire logic [gci_pkg::CH_W-1:0]     rsp_out_red,
   input  wire logic [gci_pkg::CH_W-1:0]     rsp_out_green,
   input  wire logic [gci_pkg::CH_W-1:0]     rsp_out_blue,
   output int                                fail_count,
   output int                                pending
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [gci_pkg::STATUS_W-1:0] status;
      logic [gci_pkg::CH_W-1:0]     red;
      logic [gci_pkg::CH_W-1:0]     green;
      logic [gci_pkg::CH_W-1:0]     blue;
   } gradient_beat_type;

   logic [gci_pkg::KEY_W-1:0]   stop_key_mem   [gci_pkg::MAX_STOPS_DEFAULT];
   logic [gci_pkg::COLOR_W-1:0] stop_color_mem [gci_pkg::MAX_STOPS_DEFAULT];
   int                          stop_total = 1;
   gradient_beat_type           expected_colors [$];
   gradient_beat_type           want_beat;
   gradient_beat_type           got_beat;
   int                          errors = 0;

   function automatic logic [gci_pkg::CH_W-1:0] mix_channel(int unsigned lo, int unsigned hi,
                                                            int unsigned lk, int unsigned uk,
                                                            int unsigned p);
      int unsigned num;
      int unsigned den;
      int unsigned quo;
      num = lo * (uk - p) + hi * (p - lk);
      den = uk - lk;
      quo = (den != 0) ? num / den : lo;
      return quo[gci_pkg::CH_W-1:0];
   endfunction

   function automatic gradient_beat_type color_beat(logic [gci_pkg::COLOR_W-1:0] rgb);
      gradient_beat_type beat;
      beat.status = gci_pkg::STATUS_COLOR;
      beat.red    = rgb[23:16];
      beat.green  = rgb[15:8];
      beat.blue   = rgb[7:0];
      return beat;
   endfunction

   function automatic gradient_beat_type predict_beat(logic kind,
                                                      logic [gci_pkg::KEY_W-1:0] pos,
                                                      logic [gci_pkg::COLOR_W-1:0] rgb);
      gradient_beat_type           beat;
      int                          slot;
      int                          upper;
      bit                          hit;
      logic [gci_pkg::COLOR_W-1:0] lc;
      logic [gci_pkg::COLOR_W-1:0] hc;
      beat  = '0;
      slot  = 0;
      upper = stop_total;
      hit   = 1'b0;
      if (kind == gci_pkg::REQ_INSERT) begin
         if (pos > gci_pkg::KEY_ONE) begin
            beat.status = gci_pkg::STATUS_INVALID;
         end else begin
            for (int i = 0; i < stop_total; i++) begin
               if (stop_key_mem[i] == pos) begin
                  stop_color_mem[i] = rgb;
                  hit = 1'b1;
                  break;
               end
               if (stop_key_mem[i] < pos) slot = i + 1;
            end
            if (hit) begin
               beat.status = gci_pkg::STATUS_OK;
            end else if (stop_total >= gci_pkg::MAX_STOPS_DEFAULT) begin
               beat.status = gci_pkg::STATUS_FULL;
            end else begin
               for (int i = stop_total; i > slot; i--) begin
                  stop_key_mem[i]   = stop_key_mem[i-1];
                  stop_color_mem[i] = stop_color_mem[i-1];
               end
               stop_key_mem[slot]   = pos;
               stop_color_mem[slot] = rgb;
               stop_total++;
               beat.status = gci_pkg::STATUS_OK;
            end
         end
      end else if (pos > gci_pkg::KEY_ONE) begin
         beat = color_beat(stop_color_mem[0]);
      end else begin
         for (int i = 0; i < stop_total; i++) begin
            if (stop_key_mem[i] > pos) begin
               upper = i;
               break;
            end
         end
         if (upper == stop_total) begin
            beat = color_beat(stop_color_mem[stop_total-1]);
         end else if (upper == 0) begin
            beat = color_beat(stop_color_mem[0]);
         end else begin
            lc = stop_color_mem[upper-1];
            hc = stop_color_mem[upper];
            beat.status = gci_pkg::STATUS_COLOR;
            beat.red    = mix_channel(lc[23:16], hc[23:16], stop_key_mem[upper-1],
                                      stop_key_mem[upper], pos);
            beat.green  = mix_channel(lc[15:8], hc[15:8], stop_key_mem[upper-1],
                                      stop_key_mem[upper], pos);
            beat.blue   = mix_channel(lc[7:0], hc[7:0], stop_key_mem[upper-1],
                                      stop_key_mem[upper], pos);
         end
      end
      return beat;
   endfunction

   task automatic compare_beat(gradient_beat_type want, gradient_beat_type got);
      if (got.status !== want.status) begin
         $error("status: expected %0d, actual %0d", want.status, got.status);
         errors++;
      end
      if (got.red !== want.red) begin
         $error("out_red: expected %0d, actual %0d", want.red, got.red);
         errors++;
      end
      if (got.green !== want.green) begin
         $error("out_green: expected %0d, actual %0d", want.green, got.green);
         errors++;
      end
      if (got.blue !== want.blue) begin
         $error("out_blue: expected %0d, actual %0d", want.blue, got.blue);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < gci_pkg::MAX_STOPS_DEFAULT; i++) begin
            stop_key_mem[i]   = '0;
            stop_color_mem[i] = '0;
         end
         stop_total = 1;
         expected_colors.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got_beat = {rsp_status, rsp_out_red, rsp_out_green, rsp_out_blue};
            if (expected_colors.size() == 0) begin
               $error("response beat with no request waiting: status %0d", rsp_status);
               errors++;
            end else begin
               want_beat = expected_colors.pop_front();
               compare_beat(want_beat, got_beat);
            end
         end
         if (req_valid && !req_stall) begin
            expected_colors.push_back(predict_beat(req_type, req_position,
                                      {req_stop_red, req_stop_green, req_stop_blue}));
         end
      end
      fail_count <= errors;
      pending    <= expected_colors.size();
   end

endmodule

`default_nettype wire

### verif/color_gradient_interpolator_top_tb.sv
// Testbench top for the color gradient interpolator: stimulus, stall pattern and verdict.
`default_nettype none

module color_gradient_interpolator_top_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_BEATS = 2000;
   localparam int QUIET_BEATS  = 200;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 100;

   logic                         clock          = 1'b0;
   logic                         reset          = 1'b1;
   logic                         req_valid      = 1'b0;
   logic                         req_type       = gci_pkg::REQ_INSERT;
   logic [gci_pkg::KEY_W-1:0]    req_position   = '0;
   logic [gci_pkg::CH_W-1:0]     req_stop_red   = '0;
   logic [gci_pkg::CH_W-1:0]     req_stop_green = '0;
   logic [gci_pkg::CH_W-1:0]     req_stop_blue  = '0;
   logic                         rsp_stall      = 1'b0;
   logic                         req_stall;
   logic                         rsp_valid;
   logic [gci_pkg::STATUS_W-1:0] rsp_status;
   logic [gci_pkg::CH_W-1:0]     rsp_out_red;
   logic [gci_pkg::CH_W-1:0]     rsp_out_green;
   logic [gci_pkg::CH_W-1:0]     rsp_out_blue;

   int fail_count;
   int pending;
   int cycle_count = 0;
   bit quiet       = 1'b0;
   int gap_odds    = 0;
   int stall_left  = 0;
   int run_left    = 0;
   int known_keys [$];

   always #2 clock = ~clock;

   color_gradient_interpolator_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_position   (req_position),
      .req_stop_red   (req_stop_red),
      .req_stop_green (req_stop_green),
      .req_stop_blue  (req_stop_blue),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue)
   );

   gci_gradient_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_position   (req_position),
      .req_stop_red   (req_stop_red),
      .req_stop_green (req_stop_green),
      .req_stop_blue  (req_stop_blue),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .fail_count     (fail_count),
      .pending        (pending)
   );

   // hold rsp_stall high in random bursts between free-running stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
      end else if (run_left > 0) begin
         run_left--;
         rsp_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 1) == 0) begin
         stall_left = $urandom_range(1, 15) - 1;
         run_left   = $urandom_range(1, 40);
         rsp_stall <= 1'b1;
      end else begin
         run_left = $urandom_range(1, 40);
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic logic [gci_pkg::CH_W-1:0] any_channel();
      return gci_pkg::CH_W'($urandom_range(0, 255));
   endfunction

   task automatic send_beat(logic kind, int pos, int red, int green, int blue);
      int gap;
      if (!quiet && $urandom_range(1, 4) <= gap_odds) begin
         gap = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_position   <= gci_pkg::KEY_W'(pos);
      req_stop_red   <= gci_pkg::CH_W'(red);
      req_stop_green <= gci_pkg::CH_W'(green);
      req_stop_blue  <= gci_pkg::CH_W'(blue);
      do @(posedge clock); while (req_stall);
   endtask

   task automatic insert_stop(int pos, int red, int green, int blue);
      send_beat(gci_pkg::REQ_INSERT, pos, red, green, blue);
   endtask

   task automatic lookup_at(int pos);
      send_beat(gci_pkg::REQ_LOOKUP, pos, any_channel(), any_channel(), any_channel());
   endtask

   initial begin
      int pick;
      int key;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      gap_odds = 2;

      lookup_at(0);
      lookup_at(32'h10000);
      lookup_at(32'h1FFFF);
      insert_stop(32'h10001, 255, 255, 255);
      insert_stop(32'h1FFFF, 255, 255, 255);
      insert_stop(0, 8'h10, 8'h20, 8'h30);
      insert_stop(32'h10000, 255, 255, 255);
      lookup_at(32'h8000);
      lookup_at(128 * 256);
      lookup_at(32'h10000);
      insert_stop(1, 0, 255, 0);
      lookup_at(0);
      insert_stop(32'hFFFF, 255, 0, 255);
      lookup_at(32'hFFFF);
      known_keys = '{0, 1, 32'hFFFF, 32'h10000};
      // descending keys: each new stop lands low and moves the upper ones
      for (int k = 0; k < 12; k++) begin
         key = 60000 - k * 4999;
         insert_stop(key, any_channel(), any_channel(), any_channel());
         known_keys.push_back(key);
      end
      insert_stop(30000, 1, 2, 3);
      insert_stop(32'h10000, 0, 0, 0);
      lookup_at(32'h1FFFF);

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n % 64 == 0) gap_odds = $urandom_range(0, 3);
         quiet = (n >= RANDOM_BEATS - QUIET_BEATS);
         pick  = $urandom_range(0, 99);
         key   = known_keys[$urandom_range(0, known_keys.size() - 1)];
         if (pick < 45) begin
            lookup_at($urandom_range(0, 32'h10000));
         end else if (pick < 55) begin
            lookup_at($urandom_range(0, 255) * 256);
         end else if (pick < 65) begin
            lookup_at(key + $urandom_range(0, 1));
         end else if (pick < 70) begin
            lookup_at($urandom_range(32'h10001, 32'h1FFFF));
         end else if (pick < 85) begin
            insert_stop(key, any_channel(), any_channel(), any_channel());
         end else if (pick < 93) begin
            insert_stop($urandom_range(0, 32'h10000), any_channel(), any_channel(),
                        any_channel());
         end else begin
            insert_stop($urandom_range(32'h10001, 32'h1FFFF), any_channel(),
                        any_channel(), any_channel());
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
